// File: src/ppw_pkg.sv
// shared constants for the perspective point warp block
// no dependencies
package ppw_pkg;
   localparam int COEF_W   = 48;
   localparam int SCR_W    = 16;
   localparam int NUM_REGS = 8;
   localparam int IDX_W    = 3;
   localparam int LANES    = 2;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW  = 2;

   localparam logic [63:0] ONE_Q32 = 64'd4294967296;
   localparam logic [63:0] EPS_Q32 = 64'd42950;

   localparam logic [SCR_W-1:0] SAT_MAX = 16'h7fff;
   localparam logic [SCR_W-1:0] SAT_MIN = 16'h8000;

   localparam logic [IDX_W-1:0] REG_COEF_X_TO_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_COEF_Y_TO_X = 3'd1;
   localparam logic [IDX_W-1:0] REG_OFFSET_X    = 3'd2;
   localparam logic [IDX_W-1:0] REG_COEF_X_TO_Y = 3'd3;
   localparam logic [IDX_W-1:0] REG_COEF_Y_TO_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_OFFSET_Y    = 3'd5;
   localparam logic [IDX_W-1:0] REG_PERSP_X     = 3'd6;
   localparam logic [IDX_W-1:0] REG_PERSP_Y     = 3'd7;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;
endpackage

// File: src/ppw_front.sv
// front pipeline: products, sums and clamping of the denominator
// depends on ppw_pkg
module ppw_front #(
   parameter int COORD_BITS = 10,
   parameter int NW = ppw_pkg::COEF_W + COORD_BITS + 3
) (
   input  logic clock,
   input  logic reset,
   input  logic signed [ppw_pkg::COEF_W-1:0] coef [ppw_pkg::NUM_REGS],
   input  logic in_valid,
   output logic in_ready,
   input  logic [COORD_BITS-1:0] cam_x,
   input  logic [COORD_BITS-1:0] cam_y,
   output logic out_valid,
   input  logic out_full,
   output logic signed [NW-1:0] nx,
   output logic signed [NW-1:0] ny,
   output logic signed [NW-1:0] w
);
   import ppw_pkg::*;
   localparam int PW = COEF_W + COORD_BITS + 1;

   logic en;
   logic [2:0] vld_ff;
   logic signed [PW-1:0] prod_ff [6];
   logic signed [NW-1:0] nx_ff, ny_ff, w_ff;
   logic signed [NW-1:0] nx2_ff, ny2_ff, w2_ff;
   logic signed [COORD_BITS:0] xs, ys;
   logic signed [NW-1:0] pe [6];
   logic signed [NW-1:0] offx, offy, one_w, eps_w;

   assign en = !(vld_ff[2] && out_full);
   assign in_ready = en;
   assign xs = {1'b0, cam_x};
   assign ys = {1'b0, cam_y};
   assign offx  = {{(NW-COEF_W){coef[REG_OFFSET_X][COEF_W-1]}}, coef[REG_OFFSET_X]};
   assign offy  = {{(NW-COEF_W){coef[REG_OFFSET_Y][COEF_W-1]}}, coef[REG_OFFSET_Y]};
   assign one_w = NW'(ONE_Q32);
   assign eps_w = NW'(EPS_Q32);

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         pe[i] = {{(NW-PW){prod_ff[i][PW-1]}}, prod_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= coef[REG_COEF_X_TO_X] * xs;
         prod_ff[1] <= coef[REG_COEF_Y_TO_X] * ys;
         prod_ff[2] <= coef[REG_COEF_X_TO_Y] * xs;
         prod_ff[3] <= coef[REG_COEF_Y_TO_Y] * ys;
         prod_ff[4] <= coef[REG_PERSP_X] * xs;
         prod_ff[5] <= coef[REG_PERSP_Y] * ys;
         nx_ff  <= pe[0] + pe[1] + offx;
         ny_ff  <= pe[2] + pe[3] + offy;
         w_ff   <= pe[4] + pe[5] + one_w;
         nx2_ff <= nx_ff;
         ny2_ff <= ny_ff;
         w2_ff  <= (w_ff < eps_w) ? eps_w : w_ff;
      end
   end

   assign out_valid = vld_ff[2];
   assign nx = nx2_ff;
   assign ny = ny2_ff;
   assign w  = w2_ff;
endmodule

// File: src/ppw_fifo.sv
// small queue between the front and back pipelines
// depends on ppw_pkg
module ppw_fifo #(
   parameter int WIDTH = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] push_data,
   input  logic pop,
   output logic [WIDTH-1:0] pop_data,
   output ppw_pkg::fifo_status_type status
);
   import ppw_pkg::*;

   logic [WIDTH-1:0] mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, rd_ff;
   logic [FIFO_AW:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

   assign pop_data     = mem[rd_ff];
   assign status.full  = (cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
endmodule

// File: src/ppw_back.sv
// back pipeline: rounding numerator, saturation check and 16-stage divider
// depends on ppw_pkg
module ppw_back #(
   parameter int NW = 61
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [NW-1:0] nx,
   input  logic signed [NW-1:0] ny,
   input  logic signed [NW-1:0] w,
   output logic out_valid,
   input  logic out_ready,
   output logic [ppw_pkg::SCR_W-1:0] out_x,
   output logic [ppw_pkg::SCR_W-1:0] out_y
);
   import ppw_pkg::*;
   localparam int DW = NW + 19;
   localparam int QB = SCR_W;

   logic en;
   logic vld1_ff;
   logic signed [DW-1:0] num1_ff [LANES];
   logic signed [DW-1:0] den1_ff;
   logic vld_ff [QB+1];
   logic signed [DW-1:0] rem_ff [QB+1][LANES];
   logic [QB-1:0] quo_ff [QB+1][LANES];
   logic neg_ff [QB+1][LANES];
   logic ovf_ff [QB+1][LANES];
   logic signed [DW-1:0] den_ff [QB+1];
   logic out_valid_ff;
   logic [SCR_W-1:0] out_ff [LANES];
   logic signed [DW-1:0] nxe, nye, we;

   assign en = !out_valid_ff || out_ready;
   assign in_ready = en;
   assign nxe = {{(DW-NW){nx[NW-1]}}, nx};
   assign nye = {{(DW-NW){ny[NW-1]}}, ny};
   assign we  = {{(DW-NW){w[NW-1]}}, w};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld_ff[0] <= vld1_ff;
      end
   end

   // num = 2n + w + 32768 * 2w, den = 2w
   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff[0] <= (nxe <<< 1) + we + (we <<< 16);
         num1_ff[1] <= (nye <<< 1) + we + (we <<< 16);
         den1_ff    <= we <<< 1;
         den_ff[0]  <= den1_ff;
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= num1_ff[l];
            quo_ff[0][l] <= '0;
            neg_ff[0][l] <= num1_ff[l][DW-1];
            ovf_ff[0][l] <= num1_ff[l] >= (den1_ff <<< QB);
         end
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      logic signed [DW-1:0] trial [LANES];
      logic [QB-1:0] qn [LANES];
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l] = rem_ff[k][l] - (den_ff[k] <<< (QB-1-k));
            qn[l] = quo_ff[k][l];
            qn[l][QB-1-k] = !trial[l][DW-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1] <= den_ff[k];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k+1][l] <= trial[l][DW-1] ? rem_ff[k][l] : trial[l];
               quo_ff[k+1][l] <= qn[l];
               neg_ff[k+1][l] <= neg_ff[k][l];
               ovf_ff[k+1][l] <= ovf_ff[k][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            if (neg_ff[QB][l]) out_ff[l] <= SAT_MIN;
            else if (ovf_ff[QB][l]) out_ff[l] <= SAT_MAX;
            else out_ff[l] <= {~quo_ff[QB][l][QB-1], quo_ff[QB][l][QB-2:0]};
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x = out_ff[0];
   assign out_y = out_ff[1];
endmodule

// File: src/perspective_point_warp_top.sv
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    req_cam_x, req_cam_y
// rsp       out  rsp_valid/rsp_ready    rsp_screen_x, rsp_screen_y
// csr       in   csr_valid/csr_ready    csr_index, csr_data
// one point per cycle sustained while rsp_ready stays high; front: products, sums, clamp;
// then the queue; back: numerator stage, range check, 16 divider stages, output register
// the 16-stage restoring divider sets the latency; all multipliers are pipelined
// synchronous reset clears all valid bits and loads the identity matrix
// the back stalls only on rsp_ready; the front stalls only when the queue is full
// depends on ppw_pkg, ppw_front, ppw_fifo, ppw_back
module perspective_point_warp_top #(
   parameter int COORD_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [COORD_BITS-1:0] req_cam_x,
   input  logic [COORD_BITS-1:0] req_cam_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [ppw_pkg::SCR_W-1:0] rsp_screen_x,
   output logic signed [ppw_pkg::SCR_W-1:0] rsp_screen_y,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [ppw_pkg::IDX_W-1:0] csr_index,
   input  logic [ppw_pkg::COEF_W-1:0] csr_data
);
   import ppw_pkg::*;
   localparam int NW = COEF_W + COORD_BITS + 3;

   logic signed [COEF_W-1:0] coef_ff [NUM_REGS];
   logic front_valid, push, pop;
   logic signed [NW-1:0] f_nx, f_ny, f_w, b_nx, b_ny, b_w;
   logic [3*NW-1:0] pop_data;
   logic back_ready;
   fifo_status_type fstat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_COEF_X_TO_X] <= COEF_W'(ONE_Q32);
         coef_ff[REG_COEF_Y_TO_X] <= '0;
         coef_ff[REG_OFFSET_X]    <= '0;
         coef_ff[REG_COEF_X_TO_Y] <= '0;
         coef_ff[REG_COEF_Y_TO_Y] <= COEF_W'(ONE_Q32);
         coef_ff[REG_OFFSET_Y]    <= '0;
         coef_ff[REG_PERSP_X]     <= '0;
         coef_ff[REG_PERSP_Y]     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_COEF_X_TO_X: coef_ff[REG_COEF_X_TO_X] <= csr_data;
            REG_COEF_Y_TO_X: coef_ff[REG_COEF_Y_TO_X] <= csr_data;
            REG_OFFSET_X:    coef_ff[REG_OFFSET_X]    <= csr_data;
            REG_COEF_X_TO_Y: coef_ff[REG_COEF_X_TO_Y] <= csr_data;
            REG_COEF_Y_TO_Y: coef_ff[REG_COEF_Y_TO_Y] <= csr_data;
            REG_OFFSET_Y:    coef_ff[REG_OFFSET_Y]    <= csr_data;
            REG_PERSP_X:     coef_ff[REG_PERSP_X]     <= csr_data;
            REG_PERSP_Y:     coef_ff[REG_PERSP_Y]     <= csr_data;
            default: ;
         endcase
      end
   end

   ppw_front #(.COORD_BITS(COORD_BITS), .NW(NW)) u_front (
      .clock(clock), .reset(reset), .coef(coef_ff),
      .in_valid(req_valid), .in_ready(req_ready),
      .cam_x(req_cam_x), .cam_y(req_cam_y),
      .out_valid(front_valid), .out_full(fstat.full),
      .nx(f_nx), .ny(f_ny), .w(f_w)
   );

   assign push = front_valid && !fstat.full;
   assign pop  = back_ready && !fstat.empty;

   ppw_fifo #(.WIDTH(3*NW)) u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data({f_nx, f_ny, f_w}),
      .pop(pop), .pop_data(pop_data), .status(fstat)
   );

   assign b_nx = pop_data[3*NW-1:2*NW];
   assign b_ny = pop_data[2*NW-1:NW];
   assign b_w  = pop_data[NW-1:0];

   ppw_back #(.NW(NW)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(pop), .in_ready(back_ready),
      .nx(b_nx), .ny(b_ny), .w(b_w),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_x(rsp_screen_x), .out_y(rsp_screen_y)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && fstat.full)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && fstat.empty)) else $error("queue underflow");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && fstat.empty) else $error("not idle after reset");
`endif
endmodule

// File: tb/tb_perspective_point_warp_top.sv
// testbench for perspective_point_warp_top: random and directed camera points
// checked against an in-bench fixed point homography predictor
// depends on ppw_pkg and perspective_point_warp_top
module tb_perspective_point_warp_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ppw_pkg::*;

   localparam int CB = 10;

   typedef struct {
      logic signed [SCR_W-1:0] sx;
      logic signed [SCR_W-1:0] sy;
   } screen_pt_type;

   class warp_scoreboard;
      logic signed [127:0] coef [NUM_REGS];
      screen_pt_type pending_pts [$];
      int errors;

      function new();
         errors = 0;
         reset_matrix();
      endfunction

      function void reset_matrix();
         foreach (coef[i]) coef[i] = '0;
         coef[REG_COEF_X_TO_X] = 128'sd4294967296;
         coef[REG_COEF_Y_TO_Y] = 128'sd4294967296;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
         coef[idx] = {{80{val[COEF_W-1]}}, val};
      endfunction

      function logic signed [SCR_W-1:0] round_div(logic signed [127:0] n,
                                                 logic signed [127:0] w);
         logic signed [127:0] num;
         logic signed [127:0] den;
         logic signed [127:0] q;
         num = 2 * n + w;
         den = 2 * w;
         if (num >= 0) begin
            q = num / den;
            if (q > 32767) return SAT_MAX;
            return q[SCR_W-1:0];
         end
         q = (-num) / den;
         if ((-num) % den != 0) q = q + 1;
         if (q > 32768) return SAT_MIN;
         q = -q;
         return q[SCR_W-1:0];
      endfunction

      function void note_point(logic [CB-1:0] cx, logic [CB-1:0] cy);
         logic signed [127:0] x;
         logic signed [127:0] y;
         logic signed [127:0] nx;
         logic signed [127:0] ny;
         logic signed [127:0] w;
         screen_pt_type p;
         x = {118'd0, cx};
         y = {118'd0, cy};
         nx = coef[REG_COEF_X_TO_X] * x + coef[REG_COEF_Y_TO_X] * y + coef[REG_OFFSET_X];
         ny = coef[REG_COEF_X_TO_Y] * x + coef[REG_COEF_Y_TO_Y] * y + coef[REG_OFFSET_Y];
         w = coef[REG_PERSP_X] * x + coef[REG_PERSP_Y] * y + 128'sd4294967296;
         if (w < 128'sd42950) w = 128'sd42950;
         p.sx = round_div(nx, w);
         p.sy = round_div(ny, w);
         pending_pts = {pending_pts, p};
      endfunction

      function void check_point(logic signed [SCR_W-1:0] ax, logic signed [SCR_W-1:0] ay);
         screen_pt_type p;
         if (pending_pts.size() == 0) begin
            $error("unexpected item screen_x=%0d screen_y=%0d", ax, ay);
            errors++;
            return;
         end
         p = pending_pts.pop_front();
         if (ax !== p.sx) begin
            $error("screen_x expected %0d actual %0d", p.sx, ax);
            errors++;
         end
         if (ay !== p.sy) begin
            $error("screen_y expected %0d actual %0d", p.sy, ay);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [CB-1:0] req_cam_x = '0;
   logic [CB-1:0] req_cam_y = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [SCR_W-1:0] rsp_screen_x;
   logic signed [SCR_W-1:0] rsp_screen_y;
   logic csr_valid = 0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   warp_scoreboard sb = new();

   always #10 clock = ~clock;

   perspective_point_warp_top #(.COORD_BITS(CB)) u_top (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_point(rsp_screen_x, rsp_screen_y);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_point(logic [CB-1:0] cx, logic [CB-1:0] cy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cam_x <= cx;
      req_cam_y <= cy;
      do @(posedge clock); while (!req_ready);
      sb.note_point(cx, cy);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_pts.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [COEF_W-1:0] rand_coef(int kind);
      logic [COEF_W-1:0] v;
      v = COEF_W'({$urandom, $urandom});
      case (kind)
         0: return v;
         1: return {{16{v[40]}}, v[31:0]} >>> 0;
         2: return {{14{v[33]}}, v[33:0]};
         default: return {{24{v[23]}}, v[23:0]};
      endcase
   endfunction

   task automatic random_matrix(int phase);
      logic [COEF_W-1:0] v;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (i < 6) v = (phase % 3 == 0) ? rand_coef(0) : rand_coef(2 + phase % 2);
         else v = (phase % 3 == 2) ? rand_coef(0) : rand_coef(3);
         if ($urandom_range(9) == 0) v = $urandom_range(1) ? 48'h7fff_ffff_ffff : 48'h8000_0000_0000;
         write_csr(i[IDX_W-1:0], v);
      end
   endtask

   initial begin
      logic [CB-1:0] ext [4];
      ext = '{10'd0, 10'd1023, 10'd512, 10'd341};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) send_point(ext[i], ext[j]);
      drain();
      // small and negative denominators, saturation
      write_csr(REG_PERSP_X, 48'h8000_0000_0000);
      write_csr(REG_PERSP_Y, -48'sd4194304);
      write_csr(REG_OFFSET_X, 48'h7fff_ffff_ffff);
      write_csr(REG_OFFSET_Y, 48'h8000_0000_0000);
      write_csr(REG_COEF_Y_TO_X, 48'h8000_0000_0000);
      write_csr(REG_COEF_X_TO_Y, 48'h7fff_ffff_ffff);
      for (int i = 0; i < 4; i++) send_point(ext[i], ext[3 - i]);
      send_point(10'd1, 10'd0);
      send_point(10'd0, 10'd1023);
      drain();
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 65; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 65; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         random_matrix(phase);
         for (int k = 0; k < 62; k++) send_point(CB'($urandom), CB'($urandom));
         drain();
      end
      if (sb.errors == 0 && sb.pending_pts.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
